### hdl/two_level_inclusive_cache_lru_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-level inclusive cache
// Concurrent property shorthands; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_INCLUSIVE_CACHE_LRU_MACROS_SVH
`define TWO_LEVEL_INCLUSIVE_CACHE_LRU_MACROS_SVH

`ifndef SYNTHESIS
`define TLIC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define TLIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define TLIC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TLIC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/tlic_pkg.sv
// ----------------------------------------------------------------------------
// tlic_pkg
// Shared types and constants for the two-level inclusive cache tag model.
// ----------------------------------------------------------------------------
package tlic_pkg;

    localparam int ADDR_W     = 32;
    localparam int LAT_W      = 11;
    localparam int CYC_W      = 8;
    localparam int MEM_CYC_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_L1_CYCLES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_CYCLES     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_CYCLES    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOC   = 2'd3;

    localparam logic KIND_WRITE = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RD, ST_LD, ST_EVAL, ST_BI_RD, ST_BI_LD, ST_BI,
        ST_F_RD, ST_F_LD, ST_FILL, ST_REF, ST_REF_RD, ST_REF_UPD, ST_FIN, ST_OUT
    } state_t;

    typedef struct packed {
        logic clr;
        logic cap;
        logic ld_l1;
        logic ld_l2;
        logic eval;
        logic bi_rd;
        logic bi_upd;
        logic fill;
        logic ref_chk;
        logic ref_rd;
        logic ref_upd;
        logic fin;
        logic out_ld;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic l1_hit;
        logic need_bi;
        logic alloc;
        logic dirty_vic;
        logic ref_same;
        logic out_free;
    } dp_status_t;

endpackage

### hdl/tlic_ctrl.sv
// ----------------------------------------------------------------------------
// tlic_ctrl
// Sequencer for clearing, lookup, back-invalidate, fill and LRU refresh.
// ----------------------------------------------------------------------------
module tlic_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tlic_pkg::dp_status_t status,
    output tlic_pkg::dp_cmd_t    cmd
);
    import tlic_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (status.clr_done) state_next = ST_IDLE;
            ST_IDLE:    if (s_valid) state_next = ST_RD;
            ST_RD:      state_next = ST_LD;
            ST_LD:      state_next = ST_EVAL;
            ST_EVAL: begin
                if (status.l1_hit) state_next = ST_OUT;
                else if (status.need_bi) state_next = ST_BI_RD;
                else if (status.alloc) state_next = ST_F_RD;
                else state_next = ST_FIN;
            end
            ST_BI_RD:   state_next = ST_BI_LD;
            ST_BI_LD:   state_next = ST_BI;
            ST_BI:      state_next = ST_F_RD;
            ST_F_RD:    state_next = ST_F_LD;
            ST_F_LD:    state_next = ST_FILL;
            ST_FILL:    state_next = status.dirty_vic ? ST_REF : ST_FIN;
            ST_REF:     state_next = status.ref_same ? ST_FIN : ST_REF_RD;
            ST_REF_RD:  state_next = ST_REF_UPD;
            ST_REF_UPD: state_next = ST_FIN;
            ST_FIN:     state_next = ST_OUT;
            ST_OUT:     if (status.out_free) state_next = ST_IDLE;
            default:    state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:   cmd.clr = 1'b1;
            ST_IDLE: begin
                s_ready = 1'b1;
                cmd.cap = s_valid;
            end
            ST_LD: begin
                cmd.ld_l1 = 1'b1;
                cmd.ld_l2 = 1'b1;
            end
            ST_EVAL:    cmd.eval = 1'b1;
            ST_BI_RD:   cmd.bi_rd = 1'b1;
            ST_BI_LD:   cmd.ld_l1 = 1'b1;
            ST_BI:      cmd.bi_upd = 1'b1;
            ST_F_LD:    cmd.ld_l1 = 1'b1;
            ST_FILL:    cmd.fill = 1'b1;
            ST_REF:     cmd.ref_chk = 1'b1;
            ST_REF_RD:  cmd.ref_rd = 1'b1;
            ST_REF_UPD: begin
                cmd.ref_rd  = 1'b1;
                cmd.ref_upd = 1'b1;
            end
            ST_FIN:     cmd.fin = 1'b1;
            ST_OUT:     cmd.out_ld = status.out_free;
            default:    cmd = '0;
        endcase
    end

endmodule

### hdl/tlic_dp.sv
// ----------------------------------------------------------------------------
// tlic_dp
// Tag stores, working rows, LRU ageing, configuration and result register.
// ----------------------------------------------------------------------------
module tlic_dp #(
    parameter int BLOCK_BITS  = 5,
    parameter int L1_SET_BITS = 6,
    parameter int L1_WAY_BITS = 2,
    parameter int L2_SET_BITS = 8,
    parameter int L2_WAY_BITS = 3
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tlic_pkg::dp_cmd_t                cmd,
    output tlic_pkg::dp_status_t             status,
    input  logic [tlic_pkg::ADDR_W-1:0]      s_address,
    input  logic                             s_kind,
    input  logic                             cfg_wr_en,
    input  logic [tlic_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tlic_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_l1_hit,
    output logic                             m_l2_hit,
    output logic [tlic_pkg::LAT_W-1:0]       m_latency,
    output logic                             m_l2_victim_evicted,
    output logic                             m_l1_dirty_victim
);
    import tlic_pkg::*;

    localparam int L1_WAYS  = 1 << L1_WAY_BITS;
    localparam int L2_WAYS  = 1 << L2_WAY_BITS;
    localparam int L1_SETS  = 1 << L1_SET_BITS;
    localparam int L2_SETS  = 1 << L2_SET_BITS;
    localparam int L1_TAG_W = ADDR_W - BLOCK_BITS - L1_SET_BITS;
    localparam int L2_TAG_W = ADDR_W - BLOCK_BITS - L2_SET_BITS;
    localparam int WI1_W    = (L1_WAY_BITS > 0) ? L1_WAY_BITS : 1;
    localparam int WI2_W    = (L2_WAY_BITS > 0) ? L2_WAY_BITS : 1;
    localparam int SI1_W    = (L1_SET_BITS > 0) ? L1_SET_BITS : 1;
    localparam int SI2_W    = (L2_SET_BITS > 0) ? L2_SET_BITS : 1;
    localparam int MAX_SB   = (L1_SET_BITS > L2_SET_BITS) ? L1_SET_BITS : L2_SET_BITS;
    localparam int CLR_W    = (MAX_SB > 0) ? MAX_SB : 1;
    localparam int CLR_LAST = (1 << MAX_SB) - 1;
    localparam logic [ADDR_W-1:0] L1_SMASK = ADDR_W'((64'd1 << L1_SET_BITS) - 1);
    localparam logic [ADDR_W-1:0] L2_SMASK = ADDR_W'((64'd1 << L2_SET_BITS) - 1);

    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic [L1_TAG_W-1:0] tag;
        logic [WI1_W-1:0]    age;
    } l1_ent_t;

    typedef struct packed {
        logic                valid;
        logic [L2_TAG_W-1:0] tag;
        logic [WI2_W-1:0]    age;
    } l2_ent_t;

    typedef l1_ent_t [L1_WAYS-1:0] l1_row_t;
    typedef l2_ent_t [L2_WAYS-1:0] l2_row_t;

    function automatic l1_row_t l1_touch(input l1_row_t r, input logic [WI1_W-1:0] w);
        l1_row_t          o;
        logic [WI1_W-1:0] old;
        o   = r;
        old = r[w].age;
        for (int j = 0; j < L1_WAYS; j++) begin
            if (WI1_W'(j) != w && r[j].age > old) o[j].age = r[j].age - 1'b1;
        end
        o[w].age = WI1_W'(L1_WAYS - 1);
        return o;
    endfunction

    function automatic l2_row_t l2_touch(input l2_row_t r, input logic [WI2_W-1:0] w);
        l2_row_t          o;
        logic [WI2_W-1:0] old;
        o   = r;
        old = r[w].age;
        for (int j = 0; j < L2_WAYS; j++) begin
            if (WI2_W'(j) != w && r[j].age > old) o[j].age = r[j].age - 1'b1;
        end
        o[w].age = WI2_W'(L2_WAYS - 1);
        return o;
    endfunction

    function automatic logic [WI1_W:0] l1_find(input l1_row_t r, input logic [L1_TAG_W-1:0] t);
        logic [WI1_W:0] res;
        res = '0;
        for (int j = L1_WAYS - 1; j >= 0; j--) begin
            if (r[j].valid && r[j].tag == t) res = {1'b1, WI1_W'(j)};
        end
        return res;
    endfunction

    function automatic logic [WI2_W:0] l2_find(input l2_row_t r, input logic [L2_TAG_W-1:0] t);
        logic [WI2_W:0] res;
        res = '0;
        for (int j = L2_WAYS - 1; j >= 0; j--) begin
            if (r[j].valid && r[j].tag == t) res = {1'b1, WI2_W'(j)};
        end
        return res;
    endfunction

    function automatic logic [WI1_W-1:0] l1_victim(input l1_row_t r);
        logic [WI1_W-1:0] v;
        logic             inv;
        v   = '0;
        inv = 1'b0;
        for (int j = L1_WAYS - 1; j >= 0; j--) begin
            if (r[j].age == '0) v = WI1_W'(j);
        end
        for (int j = L1_WAYS - 1; j >= 0; j--) begin
            if (!r[j].valid) begin
                v   = WI1_W'(j);
                inv = 1'b1;
            end
        end
        return inv ? v : v;
    endfunction

    function automatic logic [WI2_W-1:0] l2_victim(input l2_row_t r);
        logic [WI2_W-1:0] v;
        v = '0;
        for (int j = L2_WAYS - 1; j >= 0; j--) begin
            if (r[j].age == '0) v = WI2_W'(j);
        end
        for (int j = L2_WAYS - 1; j >= 0; j--) begin
            if (!r[j].valid) v = WI2_W'(j);
        end
        return v;
    endfunction

    function automatic l2_row_t l2_refresh(input l2_row_t r, input logic [L2_TAG_W-1:0] t);
        logic [WI2_W:0] f;
        f = l2_find(r, t);
        return f[WI2_W] ? l2_touch(r, f[WI2_W-1:0]) : r;
    endfunction

    // tag memories, one row per set
    l1_row_t l1_mem [L1_SETS];
    l2_row_t l2_mem [L2_SETS];
    l1_row_t l1_q_reg;
    l2_row_t l2_q_reg;

    logic              l1_we, l2_we;
    logic [SI1_W-1:0]  l1_waddr, l1_raddr;
    logic [SI2_W-1:0]  l2_waddr, l2_raddr;
    l1_row_t           l1_wdata;
    l2_row_t           l2_wdata;

    // configuration
    logic [CYC_W-1:0]     l1_cyc_reg, l2_cyc_reg;
    logic [MEM_CYC_W-1:0] mem_cyc_reg;
    logic                 wa_reg;

    // per-transaction state
    logic [ADDR_W-1:0] addr_reg, eaddr_reg, raddr_reg, eaddr_next, raddr_next;
    logic              wr_reg, hit1_reg, hit2_reg, ev_reg, dv_reg, t2_reg;
    logic [WI2_W-1:0]  w2_reg;
    l1_row_t           l1w_reg;
    l2_row_t           l2w_reg;
    logic [CLR_W-1:0]  clr_cnt_reg;
    logic              m_valid_reg;

    logic [L1_TAG_W-1:0] tag1, etag1;
    logic [L2_TAG_W-1:0] tag2, rtag;
    logic [SI1_W-1:0]    set1, eset1;
    logic [SI2_W-1:0]    set2, rset;
    logic [WI1_W:0]      find1, finde;
    logic [WI2_W:0]      find2;
    logic [WI1_W-1:0]    v1;
    logic [WI2_W-1:0]    v2;
    logic                hit1, hit2, alloc, bi_dirty, ref_same;
    l1_row_t             hit_base, hit_row, bi_row, fill_base, fill_row;
    l2_row_t             fin_row;

    assign tag1  = L1_TAG_W'(addr_reg >> (BLOCK_BITS + L1_SET_BITS));
    assign tag2  = L2_TAG_W'(addr_reg >> (BLOCK_BITS + L2_SET_BITS));
    assign set1  = SI1_W'((addr_reg >> BLOCK_BITS) & L1_SMASK);
    assign set2  = SI2_W'((addr_reg >> BLOCK_BITS) & L2_SMASK);
    assign etag1 = L1_TAG_W'(eaddr_reg >> (BLOCK_BITS + L1_SET_BITS));
    assign eset1 = SI1_W'((eaddr_reg >> BLOCK_BITS) & L1_SMASK);
    assign rtag  = L2_TAG_W'(raddr_reg >> (BLOCK_BITS + L2_SET_BITS));
    assign rset  = SI2_W'((raddr_reg >> BLOCK_BITS) & L2_SMASK);

    assign alloc    = wa_reg || (wr_reg != KIND_WRITE);
    assign find1    = l1_find(l1w_reg, tag1);
    assign hit1     = find1[WI1_W];
    assign find2    = l2_find(l2w_reg, tag2);
    assign hit2     = find2[WI2_W];
    assign v2       = l2_victim(l2w_reg);
    assign finde    = l1_find(l1w_reg, etag1);
    assign bi_dirty = finde[WI1_W] && l1w_reg[finde[WI1_W-1:0]].dirty;
    assign v1       = l1_victim(l1w_reg);
    assign ref_same = (rset == set2);

    assign eaddr_next = (ADDR_W'(l2w_reg[v2].tag) << (BLOCK_BITS + L2_SET_BITS))
                      | (ADDR_W'(set2) << BLOCK_BITS);
    assign raddr_next = (ADDR_W'(l1w_reg[v1].tag) << (BLOCK_BITS + L1_SET_BITS))
                      | (ADDR_W'(set1) << BLOCK_BITS);

    always_comb begin
        hit_base = l1w_reg;
        if (wr_reg == KIND_WRITE) hit_base[find1[WI1_W-1:0]].dirty = 1'b1;
        hit_row = l1_touch(hit_base, find1[WI1_W-1:0]);

        bi_row = l1w_reg;
        if (finde[WI1_W]) begin
            bi_row[finde[WI1_W-1:0]].valid = 1'b0;
            bi_row[finde[WI1_W-1:0]].dirty = 1'b0;
        end

        fill_base           = l1w_reg;
        fill_base[v1].tag   = tag1;
        fill_base[v1].valid = 1'b1;
        fill_base[v1].dirty = (wr_reg == KIND_WRITE);
        fill_row            = l1_touch(fill_base, v1);

        fin_row = t2_reg ? l2_touch(l2w_reg, w2_reg) : l2w_reg;
    end

    assign status.clr_done  = (clr_cnt_reg == CLR_W'(CLR_LAST));
    assign status.l1_hit    = hit1;
    assign status.need_bi   = !hit2 && alloc && l2w_reg[v2].valid;
    assign status.alloc     = alloc;
    assign status.dirty_vic = l1w_reg[v1].valid && l1w_reg[v1].dirty;
    assign status.ref_same  = ref_same;
    assign status.out_free  = !m_valid_reg || m_ready;

    // memory port selection
    always_comb begin
        l1_raddr = cmd.bi_rd ? eset1 : set1;
        l2_raddr = cmd.ref_rd ? rset : set2;
        l1_we    = 1'b0;
        l1_waddr = set1;
        l1_wdata = fill_row;
        l2_we    = 1'b0;
        l2_waddr = set2;
        l2_wdata = fin_row;
        if (cmd.clr) begin
            l1_we    = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(L1_SETS));
            l1_waddr = SI1_W'(clr_cnt_reg);
            l1_wdata = '0;
            l2_we    = 1'b1;
            l2_waddr = SI2_W'(clr_cnt_reg);
            l2_wdata = '0;
        end else if (cmd.eval) begin
            l1_we    = hit1;
            l1_wdata = hit_row;
        end else if (cmd.bi_upd) begin
            l1_we    = 1'b1;
            l1_waddr = eset1;
            l1_wdata = bi_row;
        end else if (cmd.fill) begin
            l1_we = 1'b1;
        end else if (cmd.ref_upd) begin
            l2_we    = 1'b1;
            l2_waddr = rset;
            l2_wdata = l2_refresh(l2_q_reg, rtag);
        end else if (cmd.fin) begin
            l2_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (l1_we) l1_mem[l1_waddr] <= l1_wdata;
        l1_q_reg <= l1_mem[l1_raddr];
    end

    always_ff @(posedge aclk) begin
        if (l2_we) l2_mem[l2_waddr] <= l2_wdata;
        l2_q_reg <= l2_mem[l2_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_cyc_reg  <= CYC_W'(1);
            l2_cyc_reg  <= CYC_W'(4);
            mem_cyc_reg <= MEM_CYC_W'(100);
            wa_reg      <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_L1_CYCLES:   l1_cyc_reg  <= cfg_wdata[CYC_W-1:0];
                CFG_L2_CYCLES:   l2_cyc_reg  <= cfg_wdata[CYC_W-1:0];
                CFG_MEM_CYCLES:  mem_cyc_reg <= cfg_wdata[MEM_CYC_W-1:0];
                CFG_WRITE_ALLOC: wa_reg      <= cfg_wdata[0];
                default:         wa_reg      <= wa_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr && !status.clr_done) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.out_ld) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            addr_reg <= s_address;
            wr_reg   <= s_kind;
            hit2_reg <= 1'b0;
            ev_reg   <= 1'b0;
            dv_reg   <= 1'b0;
            t2_reg   <= 1'b0;
        end
        if (cmd.ld_l1) l1w_reg <= l1_q_reg;
        if (cmd.eval) begin
            hit1_reg <= hit1;
            if (!hit1) begin
                hit2_reg <= hit2;
                t2_reg   <= hit2 || alloc;
                w2_reg   <= hit2 ? find2[WI2_W-1:0] : v2;
                ev_reg   <= !hit2 && alloc && l2w_reg[v2].valid;
            end
            eaddr_reg <= eaddr_next;
        end
        if (cmd.fill) begin
            dv_reg    <= status.dirty_vic;
            raddr_reg <= raddr_next;
        end

        if (cmd.ld_l2) begin
            l2w_reg <= l2_q_reg;
        end else if (cmd.eval && !hit1 && !hit2 && alloc) begin
            l2w_reg[v2].tag   <= tag2;
            l2w_reg[v2].valid <= 1'b1;
        end else if (cmd.bi_upd && bi_dirty) begin
            l2w_reg <= l2_touch(l2w_reg, w2_reg);
        end else if (cmd.ref_chk && ref_same) begin
            l2w_reg <= l2_refresh(l2w_reg, rtag);
        end

        if (cmd.out_ld) begin
            m_l1_hit            <= hit1_reg;
            m_l2_hit            <= !hit1_reg && hit2_reg;
            m_l2_victim_evicted <= ev_reg;
            m_l1_dirty_victim   <= dv_reg;
            m_latency           <= LAT_W'(l1_cyc_reg)
                                 + (hit1_reg ? '0 : (LAT_W'(l2_cyc_reg)
                                 + (hit2_reg ? '0 : LAT_W'(mem_cyc_reg))));
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### hdl/two_level_inclusive_cache_lru.sv
// ----------------------------------------------------------------------------
// two_level_inclusive_cache_lru
// Tag side of an inclusive two-level set-associative cache with age-counter LRU.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | role
//  s_        | s_valid/s_ready, s_address, s_kind        | access request
//  m_        | m_valid/m_ready, hit flags, latency       | access result
//  cfg_      | cfg_wr_en, cfg_index, cfg_wdata           | register write
//
//  One transaction at a time through a row-wide tag memory per level.
//  An L1 hit passes the row read, lookup and OUT states; a miss may also run
//  the back-invalidate, fill and L2 refresh steps, which read rows of their own.
//  After reset a clearing pass over 2**max(L1_SET_BITS, L2_SET_BITS) set rows
//  runs before s_ready rises. A waiting result holds the next one in OUT.
// ----------------------------------------------------------------------------
`include "two_level_inclusive_cache_lru_macros.svh"

module two_level_inclusive_cache_lru #(
    parameter int BLOCK_BITS  = 5,
    parameter int L1_SET_BITS = 6,
    parameter int L1_WAY_BITS = 2,
    parameter int L2_SET_BITS = 8,
    parameter int L2_WAY_BITS = 3
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tlic_pkg::ADDR_W-1:0]      s_address,
    input  logic                             s_kind,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_l1_hit,
    output logic                             m_l2_hit,
    output logic [tlic_pkg::LAT_W-1:0]       m_latency,
    output logic                             m_l2_victim_evicted,
    output logic                             m_l1_dirty_victim,
    input  logic                             cfg_wr_en,
    input  logic [tlic_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tlic_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import tlic_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tlic_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tlic_dp #(
        .BLOCK_BITS  (BLOCK_BITS),
        .L1_SET_BITS (L1_SET_BITS),
        .L1_WAY_BITS (L1_WAY_BITS),
        .L2_SET_BITS (L2_SET_BITS),
        .L2_WAY_BITS (L2_WAY_BITS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .s_address           (s_address),
        .s_kind              (s_kind),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_l1_hit            (m_l1_hit),
        .m_l2_hit            (m_l2_hit),
        .m_latency           (m_latency),
        .m_l2_victim_evicted (m_l2_victim_evicted),
        .m_l1_dirty_victim   (m_l1_dirty_victim)
    );

    `TLIC_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    `TLIC_ASSERT_IMPLY(a_hit_clean, aclk, aresetn, m_valid && m_l1_hit, !m_l2_hit && !m_l2_victim_evicted && !m_l1_dirty_victim)
    `TLIC_ASSERT_IMPLY(a_evict_on_miss, aclk, aresetn, m_valid && m_l2_victim_evicted, !m_l1_hit && !m_l2_hit)
    `TLIC_ASSERT_IMPLY(a_load_slot_free, aclk, aresetn, cmd.out_ld, !m_valid || m_ready)

endmodule
